[hdl/fba_pkg.sv]
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types and constants of the frame bitmap allocator: beat payloads,
// opcodes, status codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package fba_pkg;

  // default geometry
  localparam int unsigned NUM_FRAMES_DEF  = 65536;
  localparam int unsigned FRAME_SHIFT_DEF = 12;

  // fixed field widths
  localparam int unsigned OPCODE_W   = 3;
  localparam int unsigned START_W    = 16;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned ADDR_W     = 28;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned FIDX_W     = 16;
  localparam int unsigned KLF_W      = 16;
  localparam int unsigned MF_W       = 17;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  // internal frame bound width: holds any frame index or range end (up to 2^21 - 1)
  localparam int unsigned HI_W = 21;

  // bitmap word geometry
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned BIT_W     = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INIT        = 3'd0,
    OP_ALLOC_FIRST = 3'd1,
    OP_ALLOC_RANGE = 3'd2,
    OP_FREE_RANGE  = 3'd3,
    OP_FREE_ADDR   = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_BEYOND_LIMIT = 2'd2,
    ST_OUTSIDE_MAP  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_LAST   = 1'd0,
    CFG_MEMORY_FRAMES = 1'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_FOUND,
    S_RANGE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [START_W-1:0]  start_frame;
    logic [LEN_W-1:0]    run_length;
    logic [ADDR_W-1:0]   byte_address;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIDX_W-1:0]   frame_index;
    logic [ADDR_W-1:0]   frame_base;
  } rsp_t;

endpackage

[hdl/fba_stream_if.sv]
// ----------------------------------------------------------------------------
// fba_stream_if
// Valid/ready channel carrying one payload per beat.
// ----------------------------------------------------------------------------
interface fba_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

[hdl/frame_bitmap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_unit
// Physical frame allocator keeping one used bit per frame in a word memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per beat (opcode, start_frame, run_length,
//   byte_address); rsp_o returns exactly one beat per request (status,
//   frame_index, frame_base). cfg_we_i/cfg_idx_i/cfg_wdata_i write
//   kernel_last_frame (index 0) and memory_frames (index 1); write only
//   while no request is in flight.
//   The bitmap is a memory of NUM_FRAMES/64 words of 64 bits (1024 words
//   by default), one read and one write port. Range and free-address
//   requests stream words through a read, modify, write-back pipeline at
//   one word per cycle; allocate-first streams reads from the bottom word
//   and writes back only the word holding the frame it marks; init writes
//   every word without reading; rejected or zero-length requests touch no
//   word. One request is worked at a time; a new one is taken while a
//   finished result waits in the output register.
//   After reset the controller clears the whole bitmap, one word a cycle,
//   with req_i.ready low; config writes are still taken.
//   If rsp_o stalls, the finished result parks in the controller and no
//   further request is taken until the output register frees up.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit #(
  parameter int unsigned NUM_FRAMES  = fba_pkg::NUM_FRAMES_DEF,
  parameter int unsigned FRAME_SHIFT = fba_pkg::FRAME_SHIFT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fba_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  fba_stream_if.sink                       req_i,
  fba_stream_if.source                     rsp_o
);

  import fba_pkg::*;

  localparam int unsigned WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned HW_W    = HI_W - BIT_W;
  localparam int unsigned SPAN_W  = HI_W + FRAME_SHIFT;

  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
  localparam logic [HI_W-1:0]    MAP_END   = HI_W'(NUM_FRAMES);
  localparam logic [ADDR_W-1:0]  MAP_END_A = ADDR_W'(NUM_FRAMES);

  // ones for every bit of word w whose frame lies below bound hi
  function automatic logic [WORD_BITS-1:0] below_mask(input logic [WADDR_W-1:0] w,
                                                      input logic [HI_W-1:0]    hi);
    logic [HW_W-1:0] hw;
    logic [HW_W-1:0] ww;
    hw = hi[HI_W-1:BIT_W];
    ww = HW_W'(w);
    if (ww < hw) begin
      below_mask = '1;
    end else if (ww == hw) begin
      below_mask = ~({WORD_BITS{1'b1}} << hi[BIT_W-1:0]);
    end else begin
      below_mask = '0;
    end
  endfunction

  // configuration registers
  logic [KLF_W-1:0] klf_q;
  logic [MF_W-1:0]  mf_q;

  // controller state
  state_e               state_q, state_d;
  logic [WADDR_W-1:0]   cnt_q, cnt_d;
  logic                 issue_done_q, issue_done_d;
  logic                 rd_valid_q, rd_valid_d;
  logic [WADDR_W-1:0]   rd_word_q, rd_word_d;
  logic [HI_W-1:0]      lo_q, lo_d;
  logic [HI_W-1:0]      hi_q, hi_d;
  logic                 set_q, set_d;
  logic [WADDR_W-1:0]   last_word_q, last_word_d;
  logic [WADDR_W-1:0]   found_word_q, found_word_d;
  logic [WORD_BITS-1:0] found_free_q, found_free_d;
  logic [WORD_BITS-1:0] found_data_q, found_data_d;
  status_e              res_status_q, res_status_d;
  logic [HI_W-1:0]      res_idx_q, res_idx_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q;
  logic [HI_W-1:0]      out_idx_q;
  logic                 out_load;

  // bitmap memory and its ports
  logic [WORD_BITS-1:0] bitmap_q [WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 mem_re;
  logic                 mem_we;
  logic [WADDR_W-1:0]   mem_raddr;
  logic [WADDR_W-1:0]   mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // request decode helpers
  logic                 req_ready;
  logic [HI_W-1:0]      range_start;
  logic [HI_W-1:0]      range_end;
  logic [HI_W-1:0]      range_last;
  logic [ADDR_W-1:0]    addr_frame;
  logic [HI_W-1:0]      reserve_end;
  logic [HI_W-1:0]      klf_plus;

  // word datapath
  logic [WADDR_W-1:0]   end_word;
  logic [WORD_BITS-1:0] run_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W-1:0]     ff_bit;
  logic [HI_W-1:0]      ff_idx;
  logic [SPAN_W-1:0]    addr_span;

  // ---------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klf_q <= '0;
      mf_q  <= MF_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_KERNEL_LAST:   klf_q <= cfg_wdata_i[KLF_W-1:0];
        CFG_MEMORY_FRAMES: mf_q  <= cfg_wdata_i[MF_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // bitmap memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= bitmap_q[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // request decode
  assign range_start = HI_W'(req_i.payload.start_frame);
  assign range_end   = range_start + HI_W'(req_i.payload.run_length);
  assign range_last  = range_end - HI_W'(1);
  assign addr_frame  = req_i.payload.byte_address >> FRAME_SHIFT;
  assign klf_plus    = HI_W'(klf_q) + HI_W'(1);
  assign reserve_end = (klf_plus > MAP_END) ? MAP_END : klf_plus;

  // word masks for range and search
  assign end_word  = (state_q == S_SCAN) ? LAST_WORD : last_word_q;
  assign run_mask  = below_mask(rd_word_q, hi_q) & ~below_mask(rd_word_q, lo_q);
  assign free_bits = ~rd_data_q & below_mask(rd_word_q, MAP_END);

  // lowest free bit of the captured word
  always_comb begin
    ff_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (found_free_q[b]) ff_bit = BIT_W'(b);
    end
  end
  assign ff_idx = HI_W'({found_word_q, ff_bit});

  // ---------------------------------------------------------------------------
  // controller: next state and memory ports
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    issue_done_d = issue_done_q;
    rd_valid_d   = 1'b0;
    rd_word_d    = cnt_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    set_d        = set_q;
    last_word_d  = last_word_q;
    found_word_d = found_word_q;
    found_free_d = found_free_q;
    found_data_d = found_data_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    req_ready    = 1'b0;
    out_load     = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = rd_word_q;
    mem_wdata    = rd_data_q;

    unique case (state_q)
      // post-reset clear and init fill share the sweep
      S_CLEAR, S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = below_mask(cnt_q, hi_q);
        cnt_d     = cnt_q + WADDR_W'(1);
        if (cnt_q == LAST_WORD) begin
          state_d = (state_q == S_CLEAR) ? S_IDLE : S_RESP;
        end
      end

      S_IDLE: begin
        req_ready    = 1'b1;
        issue_done_d = 1'b0;
        if (req_i.valid) begin
          res_status_d = ST_OK;
          res_idx_d    = '0;
          unique case (op_e'(req_i.payload.opcode))
            OP_INIT: begin
              cnt_d   = '0;
              hi_d    = reserve_end;
              state_d = S_INIT;
            end
            OP_ALLOC_FIRST: begin
              cnt_d   = '0;
              state_d = S_SCAN;
            end
            OP_ALLOC_RANGE, OP_FREE_RANGE: begin
              res_idx_d = range_start;
              if (range_end > MAP_END) begin
                res_status_d = ST_OUTSIDE_MAP;
                state_d      = S_RESP;
              end else if (req_i.payload.run_length == '0) begin
                state_d = S_RESP;
              end else begin
                lo_d        = range_start;
                hi_d        = range_end;
                set_d       = (op_e'(req_i.payload.opcode) == OP_ALLOC_RANGE);
                cnt_d       = range_start[BIT_W +: WADDR_W];
                last_word_d = range_last[BIT_W +: WADDR_W];
                state_d     = S_RANGE;
              end
            end
            OP_FREE_ADDR: begin
              res_idx_d = addr_frame[HI_W-1:0];
              if (addr_frame >= MAP_END_A) begin
                res_status_d = ST_OUTSIDE_MAP;
                state_d      = S_RESP;
              end else begin
                lo_d        = addr_frame[HI_W-1:0];
                hi_d        = addr_frame[HI_W-1:0] + HI_W'(1);
                set_d       = 1'b0;
                cnt_d       = addr_frame[BIT_W +: WADDR_W];
                last_word_d = addr_frame[BIT_W +: WADDR_W];
                state_d     = S_RANGE;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      // read words in order, set or clear the run, write back
      S_RANGE: begin
        mem_re     = !issue_done_q;
        rd_valid_d = mem_re;
        if (mem_re) begin
          cnt_d = cnt_q + WADDR_W'(1);
          if (cnt_q == end_word) issue_done_d = 1'b1;
        end
        if (rd_valid_q) begin
          mem_we    = 1'b1;
          mem_wdata = set_q ? (rd_data_q | run_mask) : (rd_data_q & ~run_mask);
          if (rd_word_q == last_word_q) state_d = S_RESP;
        end
      end

      // stream words from the bottom until one has a free bit
      S_SCAN: begin
        mem_re     = !issue_done_q;
        rd_valid_d = mem_re;
        if (mem_re) begin
          cnt_d = cnt_q + WADDR_W'(1);
          if (cnt_q == end_word) issue_done_d = 1'b1;
        end
        if (rd_valid_q) begin
          if (free_bits != '0) begin
            found_word_d = rd_word_q;
            found_free_d = free_bits;
            found_data_d = rd_data_q;
            state_d      = S_FOUND;
          end else if (rd_word_q == LAST_WORD) begin
            res_status_d = ST_NO_FREE;
            res_idx_d    = '0;
            state_d      = S_RESP;
          end
        end
      end

      // check the memory limit, then mark the frame
      S_FOUND: begin
        res_idx_d = ff_idx;
        if (ff_idx >= HI_W'(mf_q)) begin
          res_status_d = ST_BEYOND_LIMIT;
        end else begin
          res_status_d = ST_OK;
          mem_we       = 1'b1;
          mem_waddr    = found_word_q;
          mem_wdata    = found_data_q | (WORD_BITS'(1) << ff_bit);
        end
        state_d = S_RESP;
      end

      // hand the result to the output register
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !rsp_o.ready);

  // ---------------------------------------------------------------------------
  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      issue_done_q <= 1'b0;
      rd_valid_q   <= 1'b0;
      hi_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      issue_done_q <= issue_done_d;
      rd_valid_q   <= rd_valid_d;
      hi_q         <= hi_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_word_q    <= rd_word_d;
    lo_q         <= lo_d;
    set_q        <= set_d;
    last_word_q  <= last_word_d;
    found_word_q <= found_word_d;
    found_free_q <= found_free_d;
    found_data_q <= found_data_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
    end
  end

  // ---------------------------------------------------------------------------
  // ports
  assign req_i.ready = req_ready;
  assign addr_span   = {out_idx_q, {FRAME_SHIFT{1'b0}}};

  assign rsp_o.valid               = out_valid_q;
  assign rsp_o.payload.status      = out_status_q;
  assign rsp_o.payload.frame_index = out_idx_q[FIDX_W-1:0];
  assign rsp_o.payload.frame_base  = addr_span[ADDR_W-1:0];

  // ---------------------------------------------------------------------------
  // assertions

  // range write-back never runs past the last word of the run
  a_range_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_RANGE) |-> (mem_waddr <= last_word_q))
    else $error("range write past last word");

  // a limit rejection always names a frame at or above memory_frames
  a_limit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_status_q == ST_BEYOND_LIMIT) |-> (res_idx_q >= HI_W'(mf_q)))
    else $error("beyond-limit status with frame inside limit");

  // allocation flips exactly one bit of the word it found
  a_alloc_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOUND && mem_we) |-> ($countones(mem_wdata ^ found_data_q) == 1))
    else $error("allocation changed other than one bit");

  // read and write-back never collide on one word
  a_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write on the same word");

endmodule
